@@ rtl/jowc_pkg.sv @@
package jowc_pkg;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Characters the parser looks for
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CTL_LIMIT = 8'd32;

	localparam logic [2:0] KEY_LAST = 3'd7;
	localparam logic [1:0] HEX_LAST = 2'd3;

	typedef enum logic [3:0] {
		PH_BEFORE_BRACE,
		PH_BEFORE_KEY,
		PH_IN_KEY,
		PH_AFTER_KEY,
		PH_BEFORE_VALUE,
		PH_IN_STRING,
		PH_ESCAPE,
		PH_HEX,
		PH_AFTER_STRING,
		PH_AFTER_BRACE,
		PH_ERROR
	} phase_t;

	// One classified request as it travels from front to back
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
		logic       is_ws;
		logic       is_hex;
		logic       is_esc;
		logic       is_ctl;
		logic       is_zero;
		logic       is_digit0;
	} byte_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fq_stat_t;

	// Key text "output" with its quotes
	function automatic logic [7:0] key_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = CH_QUOTE;
			3'd1:    c = 8'h6F;
			3'd2:    c = 8'h75;
			3'd3:    c = 8'h74;
			3'd4:    c = 8'h70;
			3'd5:    c = 8'h75;
			3'd6:    c = 8'h74;
			3'd7:    c = CH_QUOTE;
			default: c = CH_QUOTE;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/jowc_front.sv @@
module jowc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           text_byte,
	input  logic                 final_byte,
	output logic                 full,
	input  jowc_pkg::fq_stat_t   fq_stat,
	output logic                 fq_push,
	output jowc_pkg::byte_item_t fq_wdata
);
	import jowc_pkg::*;

	logic       valid_s1;
	byte_item_t item_s1;
	byte_item_t item_d;
	logic       take;

	// Classify the byte before it is registered
	always_comb begin
		item_d.text_byte  = text_byte;
		item_d.final_byte = final_byte;
		item_d.is_ws      = text_byte inside {8'd32, [8'd9:8'd13]};
		item_d.is_hex     = text_byte inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
		item_d.is_esc     = text_byte inside {CH_QUOTE, CH_BSLASH, CH_SLASH, 8'h62, 8'h66,
			8'h6E, 8'h72, 8'h74, CH_U};
		item_d.is_ctl     = text_byte < CTL_LIMIT;
		item_d.is_zero    = text_byte == 8'd0;
		item_d.is_digit0  = text_byte == CH_ZERO;
	end

	assign fq_push  = valid_s1 && !fq_stat.full;
	assign full     = valid_s1 && fq_stat.full;
	assign take     = push && !full;
	assign fq_wdata = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fq_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ rtl/jowc_fifo.sv @@
module jowc_fifo #(
	parameter int Depth = jowc_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  jowc_pkg::byte_item_t wr_data,
	input  logic                 rd_en,
	output jowc_pkg::byte_item_t rd_data,
	output jowc_pkg::fq_stat_t   stat
);
	import jowc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	byte_item_t          mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     cnt_q;

	assign stat.empty = cnt_q == '0;
	assign stat.full  = cnt_q == CntFull;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/jowc_back.sv @@
module jowc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jowc_pkg::fq_stat_t   fq_stat,
	input  jowc_pkg::byte_item_t fq_rdata,
	output logic                 fq_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic                 wrapper_ok
);
	import jowc_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] key_q, key_d;
	logic [1:0] hcnt_q, hcnt_d;
	logic       hzero_q, hzero_d;
	logic       res_valid_q;
	logic       ok_q;
	logic       emit;
	logic       verdict;

	assign fq_pop = !fq_stat.empty && (!fq_rdata.final_byte || !res_valid_q || pop);
	assign emit   = fq_pop && fq_rdata.final_byte;

	// Phase machine: one byte a cycle, unless the queue is empty or a final byte meets a waiting result
	always_comb begin
		logic [7:0] b;
		logic       zero_n;
		b       = fq_rdata.text_byte;
		zero_n  = hzero_q && fq_rdata.is_digit0;
		phase_d = phase_q;
		key_d   = key_q;
		hcnt_d  = hcnt_q;
		hzero_d = hzero_q;
		if (fq_rdata.is_zero) begin
			phase_d = PH_ERROR;
		end else begin
			case (phase_q)
				PH_BEFORE_BRACE: begin
					if (!fq_rdata.is_ws) phase_d = (b == CH_LBRACE) ? PH_BEFORE_KEY : PH_ERROR;
				end
				PH_BEFORE_KEY: begin
					if (!fq_rdata.is_ws) begin
						if (b == key_char(3'd0)) begin
							key_d   = 3'd1;
							phase_d = PH_IN_KEY;
						end else begin
							phase_d = PH_ERROR;
						end
					end
				end
				PH_IN_KEY: begin
					if (b != key_char(key_q)) begin
						phase_d = PH_ERROR;
					end else if (key_q == KEY_LAST) begin
						key_d   = 3'd0;
						phase_d = PH_AFTER_KEY;
					end else begin
						key_d = key_q + 3'd1;
					end
				end
				PH_AFTER_KEY: begin
					if (!fq_rdata.is_ws) phase_d = (b == CH_COLON) ? PH_BEFORE_VALUE : PH_ERROR;
				end
				PH_BEFORE_VALUE: begin
					if (!fq_rdata.is_ws) phase_d = (b == CH_QUOTE) ? PH_IN_STRING : PH_ERROR;
				end
				PH_IN_STRING: begin
					if (b == CH_QUOTE) phase_d = PH_AFTER_STRING;
					else if (fq_rdata.is_ctl) phase_d = PH_ERROR;
					else if (b == CH_BSLASH) phase_d = PH_ESCAPE;
				end
				PH_ESCAPE: begin
					if (!fq_rdata.is_esc) begin
						phase_d = PH_ERROR;
					end else if (b == CH_U) begin
						hcnt_d  = 2'd0;
						hzero_d = 1'b1;
						phase_d = PH_HEX;
					end else begin
						phase_d = PH_IN_STRING;
					end
				end
				PH_HEX: begin
					if (!fq_rdata.is_hex) begin
						phase_d = PH_ERROR;
					end else if (hcnt_q == HEX_LAST) begin
						hcnt_d  = 2'd0;
						hzero_d = 1'b1;
						phase_d = zero_n ? PH_ERROR : PH_IN_STRING;
					end else begin
						hzero_d = zero_n;
						hcnt_d  = hcnt_q + 2'd1;
					end
				end
				PH_AFTER_STRING: begin
					if (!fq_rdata.is_ws) phase_d = (b == CH_RBRACE) ? PH_AFTER_BRACE : PH_ERROR;
				end
				PH_AFTER_BRACE: begin
					if (!fq_rdata.is_ws) phase_d = PH_ERROR;
				end
				PH_ERROR: phase_d = PH_ERROR;
				default:  phase_d = PH_ERROR;
			endcase
		end
	end

	assign verdict = phase_d == PH_AFTER_BRACE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BEFORE_BRACE;
			key_q   <= 3'd0;
			hcnt_q  <= 2'd0;
			hzero_q <= 1'b1;
		end else if (emit) begin
			// end of text: back to reset for the next one
			phase_q <= PH_BEFORE_BRACE;
			key_q   <= 3'd0;
			hcnt_q  <= 2'd0;
			hzero_q <= 1'b1;
		end else if (fq_pop) begin
			phase_q <= phase_d;
			key_q   <= key_d;
			hcnt_q  <= hcnt_d;
			hzero_q <= hzero_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ok_q <= verdict;
		end
	end

	assign empty      = !res_valid_q;
	assign wrapper_ok = ok_q;

endmodule

@@ rtl/json_output_wrapper_checker.sv @@
// A final byte passes the front register, then a queue entry, then the phase machine into the
// result register before its verdict shows on the ports, when nothing stalls.
// Throughput: one byte per cycle while the queue has room and no verdict waits, as the phase
// machine takes a byte on every read of the queue.
// A finished verdict waits in a one-entry result register; the next final byte holds at the
// queue head until it is taken, and the queue of QueueDepth requests then fills behind it.
// Reset (arst_n low, asynchronous): queue and result emptied, parse back to before the brace.
module json_output_wrapper_checker #(
	parameter int QueueDepth = jowc_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic       wrapper_ok
);
	import jowc_pkg::*;

	// Queue between the classifying front and the parsing back
	fq_stat_t   fq_stat;
	logic       fq_push;
	logic       fq_pop;
	byte_item_t fq_wdata;
	byte_item_t fq_rdata;

	// Front: take each request, classify the byte, hand it to the queue
	jowc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.full       (full),
		.fq_stat    (fq_stat),
		.fq_push    (fq_push),
		.fq_wdata   (fq_wdata)
	);

	// Short queue: let front and back stall on their own
	jowc_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_wdata),
		.rd_en   (fq_pop),
		.rd_data (fq_rdata),
		.stat    (fq_stat)
	);

	// Back: advance the phase machine and hold each verdict until popped
	jowc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fq_stat    (fq_stat),
		.fq_rdata   (fq_rdata),
		.fq_pop     (fq_pop),
		.empty      (empty),
		.pop        (pop),
		.wrapper_ok (wrapper_ok)
	);

	// Never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fq_push |-> !fq_stat.full)
		else $error("queue written while full");

	// Never read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fq_pop |-> !fq_stat.empty)
		else $error("queue read while empty");

	// Back-pressure on the input only when the queue is full
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> fq_stat.full)
		else $error("full raised without a full queue");

	// A verdict only leaves the queue into an empty or draining result register
	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		(fq_pop && fq_rdata.final_byte) |-> (empty || pop))
		else $error("verdict would overwrite a waiting result");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import jowc_pkg::*;

	// Generous ceiling: every byte waiting out the longest sender gap plus the
	// receiver stalls and long hold-offs still ends far below this.
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned BYTE_TARGET = 1550;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned MAX_REPORTS = 10;

	// Key text as the parser expects it, first character in the top byte
	localparam logic [63:0] KEY_STR = "\"output\"";

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] text_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       wrapper_ok;

	// Byte requests still to be offered, and verdicts still to come back
	text_req_t   byte_reqs[$];
	logic        expected_verdicts[$];
	logic [7:0]  txt[$];

	// Parser state as predicted from the accepted bytes
	phase_t      parse_ph = PH_BEFORE_BRACE;
	logic [2:0]  key_idx = 3'd0;
	logic [1:0]  hex_cnt = 2'd0;
	logic        hex_zero = 1'b1;

	logic        req_taken = 1'b0;
	logic        res_taken = 1'b0;
	int unsigned send_wait = 0;
	int unsigned send_run = 0;
	int unsigned pop_wait = 0;
	int unsigned pop_run = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_cnt = 0;
	int unsigned bytes_taken = 0;
	int unsigned texts_good = 0;
	int unsigned texts_bad = 0;
	int unsigned verdicts_seen = 0;
	int unsigned errors = 0;
	int unsigned reported = 0;

	json_output_wrapper_checker u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.wrapper_ok (wrapper_ok)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit ws_byte(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit hex_byte(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit esc_byte(input logic [7:0] c);
		return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == "b" ||
			c == "f" || c == "n" || c == "r" || c == "t" || c == CH_U;
	endfunction

	// Advance the predicted parse by one accepted byte; a final byte yields
	// the verdict and puts the parse back to its starting point.
	task automatic parse_byte(input logic [7:0] c, input logic last,
			output bit give, output bit ok);
		phase_t nxt;
		bit     zero_run;
		nxt = parse_ph;
		if (c == 8'h00) begin
			nxt = PH_ERROR;
		end else begin
			case (parse_ph)
				PH_BEFORE_BRACE: begin
					if (!ws_byte(c))
						nxt = (c == CH_LBRACE) ? PH_BEFORE_KEY : PH_ERROR;
				end
				PH_BEFORE_KEY: begin
					if (!ws_byte(c)) begin
						if (c == CH_QUOTE) begin
							key_idx = 3'd1;
							nxt = PH_IN_KEY;
						end else begin
							nxt = PH_ERROR;
						end
					end
				end
				PH_IN_KEY: begin
					// no whitespace inside the key
					if (c != KEY_STR[8 * (7 - key_idx) +: 8]) begin
						nxt = PH_ERROR;
					end else if (key_idx == 3'd7) begin
						key_idx = 3'd0;
						nxt = PH_AFTER_KEY;
					end else begin
						key_idx = key_idx + 3'd1;
					end
				end
				PH_AFTER_KEY: begin
					if (!ws_byte(c))
						nxt = (c == CH_COLON) ? PH_BEFORE_VALUE : PH_ERROR;
				end
				PH_BEFORE_VALUE: begin
					if (!ws_byte(c))
						nxt = (c == CH_QUOTE) ? PH_IN_STRING : PH_ERROR;
				end
				PH_IN_STRING: begin
					if (c == CH_QUOTE)
						nxt = PH_AFTER_STRING;
					else if (c < CTL_LIMIT)
						nxt = PH_ERROR;
					else if (c == CH_BSLASH)
						nxt = PH_ESCAPE;
				end
				PH_ESCAPE: begin
					if (!esc_byte(c)) begin
						nxt = PH_ERROR;
					end else if (c == CH_U) begin
						hex_cnt = 2'd0;
						hex_zero = 1'b1;
						nxt = PH_HEX;
					end else begin
						nxt = PH_IN_STRING;
					end
				end
				PH_HEX: begin
					if (!hex_byte(c)) begin
						nxt = PH_ERROR;
					end else begin
						if (c != CH_ZERO)
							hex_zero = 1'b0;
						if (hex_cnt == 2'd3) begin
							// a code point of all zeros is refused
							zero_run = hex_zero;
							hex_cnt = 2'd0;
							hex_zero = 1'b1;
							nxt = zero_run ? PH_ERROR : PH_IN_STRING;
						end else begin
							hex_cnt = hex_cnt + 2'd1;
						end
					end
				end
				PH_AFTER_STRING: begin
					if (!ws_byte(c))
						nxt = (c == CH_RBRACE) ? PH_AFTER_BRACE : PH_ERROR;
				end
				PH_AFTER_BRACE: begin
					if (!ws_byte(c))
						nxt = PH_ERROR;
				end
				default: nxt = PH_ERROR;
			endcase
		end
		parse_ph = nxt;
		give = last;
		ok = (parse_ph == PH_AFTER_BRACE);
		if (last) begin
			parse_ph = PH_BEFORE_BRACE;
			key_idx = 3'd0;
			hex_cnt = 2'd0;
			hex_zero = 1'b1;
		end
	endtask

	// Idle gap drawn at random after one request, with occasional runs of no gap
	function automatic int unsigned draw_gap(inout int unsigned run);
		if (run != 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			run = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
	endtask

	task automatic add_ws();
		int unsigned n;
		int unsigned r;
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			r = $urandom_range(0, 5);
			txt.push_back((r == 5) ? 8'd32 : 8'(9 + r));
		end
	endtask

	function automatic logic [7:0] rand_hex();
		int unsigned r;
		if ($urandom_range(0, 2) == 0)
			return CH_ZERO;
		r = $urandom_range(0, 21);
		if (r < 10)
			return 8'("0" + r);
		if (r < 16)
			return 8'("a" + r - 10);
		return 8'("A" + r - 16);
	endfunction

	// String body of a few elements; with a flaw, one element breaks the rules
	task automatic add_body(input bit flaw);
		int unsigned n;
		int unsigned bad_at;
		int unsigned kind;
		int unsigned pos;
		logic [7:0]  c;
		bit          all_zero;
		n = $urandom_range(0, 5);
		bad_at = $urandom_range(0, n);
		for (int i = 0; i <= n; i++) begin
			if (flaw && i == bad_at) begin
				kind = $urandom_range(0, 3);
				case (kind)
					0: txt.push_back(8'($urandom_range(1, 31)));
					1: begin
						do c = 8'($urandom_range(0, 255)); while (esc_byte(c));
						txt.push_back(CH_BSLASH);
						txt.push_back(c);
					end
					2: add_str("\\u0000");
					default: begin
						// a non-hex byte somewhere among the four digits
						pos = $urandom_range(0, 3);
						add_str("\\u");
						for (int k = 0; k < pos; k++)
							txt.push_back(rand_hex());
						do c = 8'($urandom_range(0, 255)); while (hex_byte(c));
						txt.push_back(c);
					end
				endcase
			end else if (i < n) begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					do c = 8'($urandom_range(32, 255));
					while (c == CH_QUOTE || c == CH_BSLASH);
					txt.push_back(c);
				end else if (kind < 8) begin
					txt.push_back(CH_BSLASH);
					case ($urandom_range(0, 7))
						0: txt.push_back(CH_QUOTE);
						1: txt.push_back(CH_BSLASH);
						2: txt.push_back(CH_SLASH);
						3: txt.push_back("b");
						4: txt.push_back("f");
						5: txt.push_back("n");
						6: txt.push_back("r");
						default: txt.push_back("t");
					endcase
				end else begin
					add_str("\\u");
					all_zero = 1'b1;
					for (int k = 0; k < 4; k++) begin
						c = rand_hex();
						if (k == 3 && all_zero && c == CH_ZERO)
							c = "1";
						if (c != CH_ZERO)
							all_zero = 1'b0;
						txt.push_back(c);
					end
				end
			end
		end
	endtask

	// Move the assembled text onto the request queue, final mark on its last byte
	task automatic send_text();
		text_req_t r;
		for (int i = 0; i < txt.size(); i++) begin
			r.data = txt[i];
			r.last = (i == txt.size() - 1);
			byte_reqs.push_back(r);
		end
		txt.delete();
	endtask

	task automatic make_text();
		int unsigned r;
		int unsigned idx;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// noise: a few arbitrary bytes
			repeat ($urandom_range(1, 6))
				txt.push_back(8'($urandom_range(0, 255)));
		end else begin
			add_ws();
			txt.push_back(CH_LBRACE);
			add_ws();
			add_str("\"output\"");
			add_ws();
			txt.push_back(CH_COLON);
			add_ws();
			txt.push_back(CH_QUOTE);
			add_body(r < 25);
			txt.push_back(CH_QUOTE);
			add_ws();
			txt.push_back(CH_RBRACE);
			add_ws();
			if (r >= 25 && r < 45) begin
				idx = $urandom_range(0, txt.size() - 1);
				case ($urandom_range(0, 3))
					0: txt[idx] = 8'($urandom_range(0, 255));
					1: begin
						// end early, anywhere in the text
						while (txt.size() > idx + 1)
							txt.delete(txt.size() - 1);
					end
					2: txt.push_back(8'($urandom_range(0, 255)));
					default: txt[idx] = 8'h00;
				endcase
			end
		end
		send_text();
	endtask

	// Sender: offer the next request on the falling edge, hold it until taken
	always @(negedge clk) begin
		text_req_t nxt_req;
		if (arst_n && (!push || req_taken)) begin
			if (send_wait != 0) begin
				send_wait--;
				push <= 1'b0;
				text_byte <= 8'($urandom);
				final_byte <= 1'($urandom);
			end else if (byte_reqs.size() != 0) begin
				nxt_req = byte_reqs.pop_front();
				text_byte <= nxt_req.data;
				final_byte <= nxt_req.last;
				push <= 1'b1;
				send_wait = draw_gap(send_run);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: random waits per verdict, and twice a long hold-off so that
	// the block backs up and raises full against the sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				pop_wait = draw_gap(pop_run);
				if (verdicts_seen == 10 || verdicts_seen == 40)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (pop_wait != 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Monitor: predict on every accepted byte, check every accepted verdict
	always @(posedge clk) begin
		bit   give;
		bit   ok;
		logic want;
		req_taken <= arst_n && push && !full;
		res_taken <= arst_n && pop && !empty;
		if (arst_n && push && !full) begin
			bytes_taken++;
			parse_byte(text_byte, final_byte, give, ok);
			if (give) begin
				expected_verdicts.push_back(ok);
				if (ok)
					texts_good++;
				else
					texts_bad++;
			end
		end
		if (arst_n && pop && !empty) begin
			verdicts_seen++;
			if (expected_verdicts.size() == 0) begin
				errors++;
				if (reported < MAX_REPORTS) begin
					reported++;
					$display("[%0t] verdict %0b with none expected", $realtime, wrapper_ok);
				end
			end else begin
				want = expected_verdicts.pop_front();
				if (wrapper_ok !== want) begin
					errors++;
					if (reported < MAX_REPORTS) begin
						reported++;
						$display("[%0t] verdict %0d: wrapper_ok expected %0b, got %0b",
							$realtime, verdicts_seen, want, wrapper_ok);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding",
				cycle_cnt, expected_verdicts.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		// Directed: zero byte, top byte value, early end, shortest good text
		txt.push_back(8'h00);
		send_text();
		txt.push_back(8'hFF);
		send_text();
		txt.push_back(CH_LBRACE);
		send_text();
		add_str("{\"output\":\"\"}");
		send_text();

		while (byte_reqs.size() < BYTE_TARGET)
			make_text();

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Drain: every request taken, then every verdict back, then a margin
		// for anything stray that the block still holds
		while (byte_reqs.size() != 0 || push)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (expected_verdicts.size() != 0)
			errors++;

		$display("Ran %0d texts (%0d well formed, %0d refused) over %0d bytes",
			texts_good + texts_bad, texts_good, texts_bad, bytes_taken);
		$display("Checked %0d verdicts under random stalls and hold-offs; %0d errors",
			verdicts_seen, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
